### sv/c20bx_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the chacha20 keystream xor core
package c20bx_pkg;

   // double rounds per block (chacha20 proper uses ten)
   localparam int unsigned DoubleRoundsDefault = 10;

   // configuration port
   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 64;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_KEY_WORD_0  = 3'd0,
      CSR_KEY_WORD_1  = 3'd1,
      CSR_KEY_WORD_2  = 3'd2,
      CSR_KEY_WORD_3  = 3'd3,
      CSR_NONCE_LOW   = 3'd4,
      CSR_NONCE_HIGH  = 3'd5
   } csr_index_type;

   // "expand 32-byte k"
   localparam logic [31:0] Sigma0 = 32'h6170_7865;
   localparam logic [31:0] Sigma1 = 32'h3320_646e;
   localparam logic [31:0] Sigma2 = 32'h7962_2d32;
   localparam logic [31:0] Sigma3 = 32'h6b20_6574;

   // one quarter round operand set
   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
   } quad_type;

   // the four add-xor-rotate steps of a quarter round
   typedef enum logic [1:0] {
      STEP_AD_16 = 2'd0,
      STEP_CB_12 = 2'd1,
      STEP_AD_8  = 2'd2,
      STEP_CB_7  = 2'd3
   } step_type;

endpackage

### sv/c20bx_qr_step.sv
`timescale 1ns / 1ps
// one add-xor-rotate step of a chacha quarter round, selected by step code
module c20bx_qr_step (
   input  c20bx_pkg::quad_type quad_i,
   input  c20bx_pkg::step_type step_i,
   output c20bx_pkg::quad_type quad_o
);
   import c20bx_pkg::*;

   function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned r);
      return (x << r) | (x >> (32 - r));
   endfunction

   always_comb begin
      quad_o = quad_i;
      unique case (step_i)
         STEP_AD_16: begin
            quad_o.a = quad_i.a + quad_i.b;
            quad_o.d = rotl(quad_i.d ^ quad_o.a, 16);
         end
         STEP_CB_12: begin
            quad_o.c = quad_i.c + quad_i.d;
            quad_o.b = rotl(quad_i.b ^ quad_o.c, 12);
         end
         STEP_AD_8: begin
            quad_o.a = quad_i.a + quad_i.b;
            quad_o.d = rotl(quad_i.d ^ quad_o.a, 8);
         end
         STEP_CB_7: begin
            quad_o.c = quad_i.c + quad_i.d;
            quad_o.b = rotl(quad_i.b ^ quad_o.c, 7);
         end
         default: quad_o = quad_i;
      endcase
   end

endmodule

### sv/chacha20_block_xor_core.sv
`timescale 1ns / 1ps
// chacha20 (96-bit nonce, 32-bit counter) keystream xor core, top level
//
// Each request transfer carries one 8-byte word of a 64-byte block; the response
// is that word xored with its keystream bytes, bytes at or above the valid count
// forced to zero (counts above eight count as eight). A word with index zero
// starts a new block: the state is loaded from sigma, key, counter and nonce, then
// a four-lane add-xor-rotate unit (one lane per quarter round, one step per lane
// per cycle) runs all DOUBLE_ROUNDS double rounds, the final state adds the
// initial state back into the keystream store and the deliver state moves the
// result to the output register once that register is free. Words with any other
// index are served from the stored keystream straight into the output register.
// The core takes a new word whenever it is idle and its output register is empty
// or being transferred. Key and nonce registers must be written only while the
// core is idle, which the core itself does not enforce; a nonzero word index
// before the first block after reset reads unwritten keystream.
module chacha20_block_xor_core #(
   parameter int unsigned DOUBLE_ROUNDS = c20bx_pkg::DoubleRoundsDefault
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [31:0]                          req_block_counter,
   input  logic [2:0]                           req_word_index,
   input  logic [63:0]                          req_data_word,
   input  logic [3:0]                           req_byte_count,
   input  logic                                 req_last_word,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [63:0]                          rsp_result_word,
   output logic [3:0]                           rsp_valid_bytes,
   output logic                                 rsp_end_of_block,
   // configuration writes
   input  logic                                 csr_write,
   input  logic [c20bx_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [c20bx_pkg::CsrDataWidth-1:0]   csr_data
);
   import c20bx_pkg::*;

   localparam int unsigned RoundWidth = $clog2(DOUBLE_ROUNDS);
   localparam logic [RoundWidth-1:0] RoundLast = RoundWidth'(DOUBLE_ROUNDS - 1);

   typedef enum logic [3:0] {
      S_IDLE    = 4'b0001,
      S_ROUND   = 4'b0010,
      S_FINAL   = 4'b0100,
      S_DELIVER = 4'b1000
   } state_type;

   // key and nonce registers
   logic [63:0] key_ff [4];
   logic [63:0] nonce_low_ff;
   logic [31:0] nonce_high_ff;

   // sequencer
   state_type             state_ff, state_in;
   step_type              step_ff, step_in;
   logic                  diag_ff, diag_in;
   logic [RoundWidth-1:0] round_ff, round_in;

   // round state, keystream and the word waiting for its block
   logic [31:0] ws_ff [16];
   logic [31:0] ws_in [16];
   logic [63:0] ks_ff [8];
   logic [31:0] counter_ff;
   logic [63:0] data_ff;
   logic [3:0]  count_ff;
   logic        last_ff;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_word_ff;
   logic [3:0]  rsp_count_ff;
   logic        rsp_last_ff;

   logic        out_free;
   logic        req_fire;
   logic        load_out;
   logic [31:0] init_word [16];
   logic [31:0] init_counter;
   logic [2:0]  ks_addr;
   logic [63:0] ks_word;
   logic [63:0] src_data;
   logic [3:0]  src_count;
   logic        src_last;
   logic [3:0]  sat_count;
   logic [63:0] result_word;
   logic [3:0]  lane_idx [4][4];
   quad_type    lane_quad [4];
   quad_type    lane_next [4];

   // handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == S_IDLE) && out_free);
   assign req_fire  = req_valid && !req_stall;

   // initial state: counter from the request on load, from the latch on add-back
   assign init_counter = (state_ff == S_IDLE) ? req_block_counter : counter_ff;

   always_comb begin
      init_word[0]  = Sigma0;
      init_word[1]  = Sigma1;
      init_word[2]  = Sigma2;
      init_word[3]  = Sigma3;
      for (int i = 0; i < 4; i++) begin
         init_word[4 + 2 * i] = key_ff[i][31:0];
         init_word[5 + 2 * i] = key_ff[i][63:32];
      end
      init_word[12] = init_counter;
      init_word[13] = nonce_low_ff[31:0];
      init_word[14] = nonce_low_ff[63:32];
      init_word[15] = nonce_high_ff;
   end

   // lane l, role r: column round uses word 4r+l, diagonal round 4r+((l+r) mod 4)
   always_comb begin
      for (int l = 0; l < 4; l++) begin
         for (int r = 0; r < 4; r++) begin
            lane_idx[l][r] = {2'(r), 2'(2'(l) + (diag_ff ? 2'(r) : 2'd0))};
         end
         lane_quad[l].a = ws_ff[lane_idx[l][0]];
         lane_quad[l].b = ws_ff[lane_idx[l][1]];
         lane_quad[l].c = ws_ff[lane_idx[l][2]];
         lane_quad[l].d = ws_ff[lane_idx[l][3]];
      end
   end

   for (genvar g = 0; g < 4; g++) begin : g_lane
      c20bx_qr_step u_step (
         .quad_i (lane_quad[g]),
         .step_i (step_ff),
         .quad_o (lane_next[g])
      );
   end

   // response payload: request fields when idle, latched word after a block
   assign ks_addr   = (state_ff == S_IDLE) ? req_word_index : 3'd0;
   assign ks_word   = ks_ff[ks_addr];
   assign src_data  = (state_ff == S_IDLE) ? req_data_word  : data_ff;
   assign src_count = (state_ff == S_IDLE) ? req_byte_count : count_ff;
   assign src_last  = (state_ff == S_IDLE) ? req_last_word  : last_ff;
   assign sat_count = (src_count > 4'd8) ? 4'd8 : src_count;

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         result_word[8 * k +: 8] = (4'(k) < sat_count) ?
                                   (src_data[8 * k +: 8] ^ ks_word[8 * k +: 8]) : 8'h00;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      diag_in  = diag_ff;
      round_in = round_ff;
      load_out = 1'b0;
      ws_in    = ws_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_word_index == 3'd0) begin
                  ws_in    = init_word;
                  step_in  = STEP_AD_16;
                  diag_in  = 1'b0;
                  round_in = '0;
                  state_in = S_ROUND;
               end else begin
                  load_out = 1'b1;
               end
            end
         end
         S_ROUND: begin
            for (int l = 0; l < 4; l++) begin
               ws_in[lane_idx[l][0]] = lane_next[l].a;
               ws_in[lane_idx[l][1]] = lane_next[l].b;
               ws_in[lane_idx[l][2]] = lane_next[l].c;
               ws_in[lane_idx[l][3]] = lane_next[l].d;
            end
            step_in = step_type'(step_ff + 2'd1);
            if (step_ff == STEP_CB_7) begin
               diag_in = !diag_ff;
               if (diag_ff) begin
                  round_in = round_ff + 1'b1;
                  if (round_ff == RoundLast) begin
                     round_in = round_ff;
                     state_in = S_FINAL;
                  end
               end
            end
         end
         S_FINAL: begin
            state_in = S_DELIVER;
         end
         S_DELIVER: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // a new word replaces the old one; otherwise the old one clears on transfer
   assign rsp_valid_in = load_out || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         step_ff       <= STEP_AD_16;
         diag_ff       <= 1'b0;
         round_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         key_ff        <= '{default: '0};
         nonce_low_ff  <= '0;
         nonce_high_ff <= '0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         diag_ff      <= diag_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            unique case (csr_index)
               CSR_KEY_WORD_0: key_ff[0]     <= csr_data;
               CSR_KEY_WORD_1: key_ff[1]     <= csr_data;
               CSR_KEY_WORD_2: key_ff[2]     <= csr_data;
               CSR_KEY_WORD_3: key_ff[3]     <= csr_data;
               CSR_NONCE_LOW:  nonce_low_ff  <= csr_data;
               CSR_NONCE_HIGH: nonce_high_ff <= csr_data[31:0];
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ws_ff <= ws_in;
      if (req_fire) begin
         counter_ff <= req_block_counter;
         data_ff    <= req_data_word;
         count_ff   <= req_byte_count;
         last_ff    <= req_last_word;
      end
      if (state_ff == S_FINAL) begin
         for (int i = 0; i < 8; i++) begin
            ks_ff[i] <= {ws_ff[2 * i + 1] + init_word[2 * i + 1],
                         ws_ff[2 * i] + init_word[2 * i]};
         end
      end
      if (load_out) begin
         rsp_word_ff  <= result_word;
         rsp_count_ff <= sat_count;
         rsp_last_ff  <= src_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_word  = rsp_word_ff;
   assign rsp_valid_bytes  = rsp_count_ff;
   assign rsp_end_of_block = rsp_last_ff;

   // a keystream hit is answered in the very next cycle
   a_hit_answers: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_word_index != 3'd0) |=> rsp_valid)
      else $error("keystream hit not answered next cycle");

   // a block start always enters the round loop at its first step
   a_block_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_word_index == 3'd0) |=>
      (state_ff == S_ROUND) && (step_ff == STEP_AD_16) && !diag_ff && (round_ff == '0))
      else $error("block start did not enter round loop cleanly");

   // the loop leaves only after the last diagonal step of the last double round
   a_round_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROUND) && (state_in == S_FINAL) |->
      diag_ff && (step_ff == STEP_CB_7) && (round_ff == RoundLast))
      else $error("round loop left early");

   // the output register is never overwritten while a response is stalled
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !load_out)
      else $error("stalled response overwritten");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for the chacha20 keystream xor core
module testbench;
   import c20bx_pkg::*;

   // timing of the run
   localparam int unsigned DoubleRounds = DoubleRoundsDefault;
   localparam int unsigned BlockLatency = 8 * DoubleRounds + 3; // busy cycles of a first word
   localparam int unsigned CycleLimit   = 1000000;
   localparam int unsigned HoldAfter    = 400;   // accepted words before the long hold-off
   localparam int unsigned HoldCycles   = 600;
   localparam int unsigned PrintLimit   = 40;

   // word index that starts a new keystream block
   localparam logic [2:0] FirstWordIndex = 3'd0;
   // register indexes with no register behind them
   localparam logic [CsrIndexWidth-1:0] CsrUnusedLow  = 3'd6;
   localparam logic [CsrIndexWidth-1:0] CsrUnusedHigh = 3'd7;

   // the four sigma words, little-endian "expand 32-byte k"
   localparam logic [31:0] ExpandWord0 = 32'h6170_7865;
   localparam logic [31:0] ExpandWord1 = 32'h3320_646e;
   localparam logic [31:0] ExpandWord2 = 32'h7962_2d32;
   localparam logic [31:0] ExpandWord3 = 32'h6b20_6574;

   typedef struct packed {
      logic [31:0] block_counter;
      logic [2:0]  word_index;
      logic [63:0] data_word;
      logic [3:0]  byte_count;
      logic        last_word;
   } word_item_type;

   typedef struct packed {
      logic [63:0] result_word;
      logic [3:0]  valid_bytes;
      logic        end_of_block;
   } xor_result_type;

   // clock, reset and block ports, every driven input known from time zero
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_block_counter = '0;
   logic [2:0]  req_word_index = '0;
   logic [63:0] req_data_word = '0;
   logic [3:0]  req_byte_count = '0;
   logic        req_last_word = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_result_word;
   logic [3:0]  rsp_valid_bytes;
   logic        rsp_end_of_block;
   logic                     csr_write = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0]  csr_data = '0;

   // predictor state: register copies, round state and keystream of the last block
   logic [63:0] key_copy [4];
   logic [63:0] nonce_low_copy;
   logic [31:0] nonce_high_copy;
   logic [31:0] mix_state [16];
   logic [63:0] keystream [8];

   // words waiting to be sent and results waiting to arrive
   word_item_type  pending_words [$];
   xor_result_type expected_words [$];

   int unsigned mismatch_count = 0;
   int unsigned accepted_words = 0;
   int unsigned cycle_count = 0;
   logic        req_taken = 1'b0;    // request transfer at the last rising edge
   logic        steady = 1'b0;       // no idling on either side while set
   logic        rsp_hold = 1'b0;     // long receiver hold-off
   int unsigned send_gap = 0;
   int unsigned stall_left = 0;
   word_item_type  next_word;
   word_item_type  seen_word;
   xor_result_type wanted;

   chacha20_block_xor_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_block_counter(req_block_counter),
      .req_word_index   (req_word_index),
      .req_data_word    (req_data_word),
      .req_byte_count   (req_byte_count),
      .req_last_word    (req_last_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_word  (rsp_result_word),
      .rsp_valid_bytes  (rsp_valid_bytes),
      .rsp_end_of_block (rsp_end_of_block),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // 2 ns clock
   initial begin
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [31:0] rotate_left(logic [31:0] x, int unsigned r);
      return (x << r) | (x >> (32 - r));
   endfunction

   // one quarter round on the shared round state
   function automatic void quarter_round(int unsigned a, int unsigned b, int unsigned c,
                                         int unsigned d);
      mix_state[a] = mix_state[a] + mix_state[b];
      mix_state[d] = rotate_left(mix_state[d] ^ mix_state[a], 16);
      mix_state[c] = mix_state[c] + mix_state[d];
      mix_state[b] = rotate_left(mix_state[b] ^ mix_state[c], 12);
      mix_state[a] = mix_state[a] + mix_state[b];
      mix_state[d] = rotate_left(mix_state[d] ^ mix_state[a], 8);
      mix_state[c] = mix_state[c] + mix_state[d];
      mix_state[b] = rotate_left(mix_state[b] ^ mix_state[c], 7);
   endfunction

   // full chacha20 block for one counter value, kept as eight 64-bit words
   function automatic void refresh_keystream(logic [31:0] counter);
      logic [31:0] start_words [16];
      int unsigned i;
      start_words[0] = ExpandWord0;
      start_words[1] = ExpandWord1;
      start_words[2] = ExpandWord2;
      start_words[3] = ExpandWord3;
      for (i = 0; i < 4; i++) begin
         start_words[4 + 2 * i] = key_copy[i][31:0];
         start_words[5 + 2 * i] = key_copy[i][63:32];
      end
      start_words[12] = counter;
      start_words[13] = nonce_low_copy[31:0];
      start_words[14] = nonce_low_copy[63:32];
      start_words[15] = nonce_high_copy;
      for (i = 0; i < 16; i++) mix_state[i] = start_words[i];
      for (i = 0; i < DoubleRounds; i++) begin
         // column round
         quarter_round(0, 4, 8, 12);
         quarter_round(1, 5, 9, 13);
         quarter_round(2, 6, 10, 14);
         quarter_round(3, 7, 11, 15);
         // diagonal round
         quarter_round(0, 5, 10, 15);
         quarter_round(1, 6, 11, 12);
         quarter_round(2, 7, 8, 13);
         quarter_round(3, 4, 9, 14);
      end
      for (i = 0; i < 8; i++) begin
         keystream[i] = {mix_state[2 * i + 1] + start_words[2 * i + 1],
                         mix_state[2 * i] + start_words[2 * i]};
      end
   endfunction

   // expected result of one accepted word
   function automatic xor_result_type xor_with_keystream(word_item_type w);
      xor_result_type res;
      logic [3:0]  kept;
      int unsigned k;
      if (w.word_index == FirstWordIndex) refresh_keystream(w.block_counter);
      // counts above eight saturate, zero keeps no byte at all
      kept = (w.byte_count > 4'd8) ? 4'd8 : w.byte_count;
      res.result_word = '0;
      for (k = 0; k < 8; k++) begin
         if (k < kept)
            res.result_word[8 * k +: 8] = w.data_word[8 * k +: 8]
                                        ^ keystream[w.word_index][8 * k +: 8];
      end
      res.valid_bytes = kept;
      res.end_of_block = w.last_word;
      return res;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(string what, logic [63:0] seen, logic [63:0] due);
      if (mismatch_count < PrintLimit)
         $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, seen, due);
      mismatch_count++;
   endtask

   // monitor: checks response transfers, then predicts each request transfer;
   // a response can never belong to a request taken at the same edge
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               report_mismatch("response with none outstanding", rsp_result_word, '0);
            end else begin
               wanted = expected_words.pop_front();
               if (rsp_result_word !== wanted.result_word)
                  report_mismatch("result_word", rsp_result_word, wanted.result_word);
               if (rsp_valid_bytes !== wanted.valid_bytes)
                  report_mismatch("valid_bytes", 64'(rsp_valid_bytes), 64'(wanted.valid_bytes));
               if (rsp_end_of_block !== wanted.end_of_block)
                  report_mismatch("end_of_block", 64'(rsp_end_of_block),
                                  64'(wanted.end_of_block));
            end
         end
         if (req_valid && !req_stall) begin
            seen_word.block_counter = req_block_counter;
            seen_word.word_index = req_word_index;
            seen_word.data_word = req_data_word;
            seen_word.byte_count = req_byte_count;
            seen_word.last_word = req_last_word;
            expected_words.push_back(xor_with_keystream(seen_word));
            accepted_words <= accepted_words + 1;
         end
      end
   end

   // ---------------------------------------------------------------- idling

   // idle stretch: mostly short, now and then long
   function automatic int unsigned idle_length();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return $urandom_range(1, 3);
      else if (pick < 95) return $urandom_range(4, 10);
      else return $urandom_range(20, 80);
   endfunction

   // driver: a payload only moves on after its transfer, then a random gap
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap != 0) begin
            req_valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (pending_words.size() != 0) begin
            next_word = pending_words.pop_front();
            req_valid <= 1'b1;
            req_block_counter <= next_word.block_counter;
            req_word_index <= next_word.word_index;
            req_data_word <= next_word.data_word;
            req_byte_count <= next_word.byte_count;
            req_last_word <= next_word.last_word;
            send_gap <= (steady || $urandom_range(0, 2) != 0) ? 0 : idle_length();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls, overridden by the long hold-off
   always @(negedge clock) begin
      if (rsp_hold) begin
         rsp_stall <= 1'b1;
      end else if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= idle_length() - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // long hold-off mid-run: the sender keeps offering so the core backs up
   initial begin
      wait (accepted_words >= HoldAfter);
      @(negedge clock);
      rsp_hold <= 1'b1;
      repeat (HoldCycles) @(negedge clock);
      rsp_hold <= 1'b0;
   end

   // cycle limit
   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   // ---------------------------------------------------------------- stimulus

   function automatic logic [63:0] random_word();
      return {$urandom, $urandom};
   endfunction

   task automatic queue_word(logic [31:0] counter, logic [2:0] index, logic [63:0] data,
                             logic [3:0] count, logic last);
      word_item_type w;
      w.block_counter = counter;
      w.word_index = index;
      w.data_word = data;
      w.byte_count = count;
      w.last_word = last;
      pending_words.push_back(w);
   endtask

   // register write, mirrored in the predictor; write enable left high
   task automatic write_register(logic [CsrIndexWidth-1:0] index, logic [63:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      unique case (index)
         CSR_KEY_WORD_0: key_copy[0] = value;
         CSR_KEY_WORD_1: key_copy[1] = value;
         CSR_KEY_WORD_2: key_copy[2] = value;
         CSR_KEY_WORD_3: key_copy[3] = value;
         CSR_NONCE_LOW:  nonce_low_copy = value;
         CSR_NONCE_HIGH: nonce_high_copy = value[31:0];
         default: ;
      endcase
   endtask

   // full key and nonce, plus writes to the unused indexes that must change nothing
   task automatic program_key(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                              logic [63:0] k3, logic [63:0] n_low, logic [63:0] n_high);
      write_register(CSR_KEY_WORD_0, k0);
      write_register(CSR_KEY_WORD_1, k1);
      write_register(CSR_KEY_WORD_2, k2);
      write_register(CSR_KEY_WORD_3, k3);
      write_register(CSR_NONCE_LOW, n_low);
      write_register(CSR_NONCE_HIGH, n_high);
      write_register(CsrUnusedLow, random_word());
      write_register(CsrUnusedHigh, random_word());
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // wait until every word is sent and every result is in, then let the core settle
   task automatic wait_drained();
      @(posedge clock);
      while (pending_words.size() != 0 || req_valid || expected_words.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // mostly well-formed blocks with random content, some stray words
   task automatic queue_random_words(int unsigned target);
      int unsigned queued;
      int unsigned len;
      int unsigned i;
      int unsigned pick;
      logic [31:0] counter;
      queued = 0;
      while (queued < target) begin
         pick = $urandom_range(0, 9);
         if (pick < 8) begin
            len = $urandom_range(1, 8);
            counter = (pick == 0) ? '1 : (pick == 1) ? '0 : 32'($urandom);
            for (i = 0; i < len; i++)
               queue_word(counter, 3'(i), random_word(),
                          (i == len - 1) ? 4'($urandom_range(1, 8)) : 4'd8, i == len - 1);
            queued += len;
         end else begin
            queue_word($urandom, 3'($urandom_range(0, 7)), random_word(),
                       4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
            queued++;
         end
      end
   endtask

   // main sequence
   initial begin
      int unsigned i;
      // predictor starts from the reset values
      for (i = 0; i < 4; i++) key_copy[i] = '0;
      nonce_low_copy = '0;
      nonce_high_copy = '0;
      for (i = 0; i < 8; i++) keystream[i] = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // directed, reset key: a full block first so no word reads an unwritten keystream
      queue_word('0, FirstWordIndex, '0, 4'd8, 1'b0);
      queue_word('0, 3'd1, '1, 4'd8, 1'b0);
      queue_word('0, 3'd2, random_word(), 4'd0, 1'b0);   // no valid byte
      queue_word('0, 3'd3, '1, 4'd1, 1'b0);
      queue_word('0, 3'd4, '1, 4'd9, 1'b0);              // count saturates
      queue_word('0, 3'd5, random_word(), 4'd15, 1'b0);
      queue_word('0, 3'd6, random_word(), 4'd7, 1'b0);
      queue_word('0, 3'd7, '1, 4'd8, 1'b1);
      // one-word block at the top counter, then a word out of order from it
      queue_word('1, FirstWordIndex, '1, 4'd8, 1'b1);
      queue_word('1, 3'd5, random_word(), 4'd3, 1'b0);
      wait_drained();

      // directed, all-ones key and nonce
      program_key('1, '1, '1, '1, '1, '1);
      for (i = 0; i < 8; i++)
         queue_word('1, 3'(i), random_word(), (i == 7) ? 4'd5 : 4'd8, i == 7);
      queue_word('0, FirstWordIndex, '0, 4'd4, 1'b1);
      queue_word('0, FirstWordIndex, '1, 4'd8, 1'b0);
      queue_word(32'h8000_0000, 3'd7, '1, 4'd8, 1'b1);   // counter ignored off index zero
      wait_drained();

      // random keys, one phase with no idling at all
      for (i = 0; i < 4; i++) begin
         program_key(random_word(), random_word(), random_word(), random_word(),
                     random_word(), random_word());
         steady = (i == 2);
         queue_random_words(225);
         wait_drained();
      end
      steady = 1'b0;

      // back to an all-zero key, written explicitly
      program_key('0, '0, '0, '0, '0, '0);
      queue_random_words(100);
      wait_drained();

      // anything arriving now has no expectation and is caught by the monitor
      repeat (2 * BlockLatency) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
